// File: design/bct_pkg.sv
// Shared types and constants for the buffer change tracker.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package bct_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_SLOTS         = 16;
    localparam int DEF_ADDRESS_WIDTH = 32;

    // Widths of the request and configuration fields.
    localparam int ADDR_PORT_W = 32;
    localparam int SIZE_W      = 16;
    localparam int CRC_W       = 16;
    localparam int CFG_W       = 5;

    // Reset value of the active slot count.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture an accepted request
        logic compare;  // register the per-slot match flags
        logic commit;   // write the slot table and present the result
    } t_cmd;

endpackage

// File: design/bct_ctrl.sv
// Controller state machine for the buffer change tracker.
// Depends on bct_pkg; drives the command struct to bct_datapath.
`timescale 1ns / 1ps

module bct_ctrl
    import bct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // A request can be taken while idle or while the previous result is shown.
    assign w_accept = i_start && ((r_state == ST_IDLE) || (r_state == ST_UPDATE));

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_COMPARE;
            end
            ST_COMPARE: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = w_accept ? ST_COMPARE : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb begin
        o_cmd.load    = w_accept;
        o_cmd.compare = 1'b0;
        o_cmd.commit  = 1'b0;
        o_busy        = 1'b0;
        o_valid       = 1'b0;
        case (r_state)
            ST_IDLE: begin
            end
            ST_COMPARE: begin
                o_cmd.compare = 1'b1;
                o_busy        = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.commit = 1'b1;
                o_valid      = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: design/bct_datapath.sv
// Datapath of the buffer change tracker: slot table, parallel compare and update.
// Depends on bct_pkg; commanded by bct_ctrl.
`timescale 1ns / 1ps

module bct_datapath
    import bct_pkg::*;
#(
    parameter int SLOTS         = DEF_SLOTS,
    parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic [ADDR_PORT_W-1:0] i_block_address,
    input  logic [SIZE_W-1:0]      i_block_size,
    input  logic [CRC_W-1:0]       i_block_crc,
    output logic                   o_changed
);

    localparam int KEY_W = (ADDRESS_WIDTH < ADDR_PORT_W) ? ADDRESS_WIDTH : ADDR_PORT_W;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int NW    = (CW > CFG_W) ? CW : CFG_W;

    // Configuration register.
    logic [CFG_W-1:0] r_active;

    // Captured request.
    logic [KEY_W-1:0]  r_req_addr;
    logic [SIZE_W-1:0] r_req_size;
    logic [CRC_W-1:0]  r_req_crc;

    // Slot table.
    logic [KEY_W-1:0]  r_slot_addr [SLOTS];
    logic [SIZE_W-1:0] r_slot_size [SLOTS];
    logic [CRC_W-1:0]  r_slot_crc  [SLOTS];
    logic [SLOTS-1:0]  r_slot_vld;

    // Registered compare flags.
    logic [SLOTS-1:0] r_match;
    logic [SLOTS-1:0] r_free;
    logic [SLOTS-1:0] r_crc_eq;

    logic [NW-1:0]    w_n_use;
    logic [SLOTS-1:0] w_in_range;
    logic [SLOTS-1:0] w_last;
    logic [SLOTS-1:0] w_stop;
    logic [SLOTS-1:0] w_first;
    logic             w_addr_nz;
    logic             w_shift;

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_data;
        end
    end

    // Slots in use: zero counts as one, anything above the table size saturates.
    always_comb begin
        if (r_active == '0) begin
            w_n_use = NW'(1);
        end else if (NW'(r_active) > NW'(SLOTS)) begin
            w_n_use = NW'(SLOTS);
        end else begin
            w_n_use = NW'(r_active);
        end
    end

    // Range and last-slot masks for the active part of the table.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_in_range[i] = NW'(i) < w_n_use;
            w_last[i]     = NW'(i) == (w_n_use - NW'(1));
        end
    end

    // Request capture on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_addr <= i_block_address[KEY_W-1:0];
            r_req_size <= i_block_size;
            r_req_crc  <= i_block_crc;
        end
    end

    // Parallel compare of the request against every active slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_match[i]  <= w_in_range[i] && r_slot_vld[i] &&
                               (r_slot_addr[i] == r_req_addr) &&
                               (r_slot_size[i] == r_req_size);
                r_free[i]   <= w_in_range[i] && !r_slot_vld[i];
                r_crc_eq[i] <= r_slot_crc[i] == r_req_crc;
            end
        end
    end

    // The lowest slot that is either free or matching decides the outcome.
    assign w_stop    = r_match | r_free;
    assign w_first   = w_stop & (~w_stop + SLOTS'(1));
    assign w_addr_nz = r_req_addr != '0;
    assign w_shift   = w_addr_nz && (w_stop == '0);

    // Unchanged only when the deciding slot matches with an equal CRC.
    assign o_changed = !(w_addr_nz && ((w_first & r_match & r_crc_eq) != '0));

    // Per-slot update: shift toward slot zero, fill a free slot, or refresh the CRC.
    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        logic [KEY_W-1:0]  w_next_addr;
        logic [SIZE_W-1:0] w_next_size;
        logic [CRC_W-1:0]  w_next_crc;
        logic              w_next_vld;

        if (g < SLOTS - 1) begin : g_up
            assign w_next_addr = r_slot_addr[g+1];
            assign w_next_size = r_slot_size[g+1];
            assign w_next_crc  = r_slot_crc[g+1];
            assign w_next_vld  = r_slot_vld[g+1];
        end else begin : g_top
            assign w_next_addr = r_req_addr;
            assign w_next_size = r_req_size;
            assign w_next_crc  = r_req_crc;
            assign w_next_vld  = 1'b1;
        end

        // Slot payload.
        always_ff @(posedge i_clk) begin
            if (i_cmd.commit && w_in_range[g]) begin
                if (w_shift) begin
                    if (w_last[g]) begin
                        r_slot_addr[g] <= r_req_addr;
                        r_slot_size[g] <= r_req_size;
                        r_slot_crc[g]  <= r_req_crc;
                    end else begin
                        r_slot_addr[g] <= w_next_addr;
                        r_slot_size[g] <= w_next_size;
                        r_slot_crc[g]  <= w_next_crc;
                    end
                end else if (w_addr_nz && w_first[g]) begin
                    if (r_free[g]) begin
                        r_slot_addr[g] <= r_req_addr;
                        r_slot_size[g] <= r_req_size;
                    end
                    r_slot_crc[g] <= r_req_crc;
                end
            end
        end

        // Slot valid bit.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slot_vld[g] <= 1'b0;
            end else if (i_cmd.commit && w_in_range[g]) begin
                if (w_shift) begin
                    r_slot_vld[g] <= w_last[g] ? 1'b1 : w_next_vld;
                end else if (w_addr_nz && w_first[g]) begin
                    r_slot_vld[g] <= 1'b1;
                end
            end
        end
    end

endmodule

// File: design/buffer_change_tracker.sv
// The result strobe o_valid follows the accepting edge through the compare state and then the update state.
// The slot compare and the table update each have their own state, and a new request
// can be taken during the update state, while the previous result is shown.
// busy is high only in the compare cycle. The receiver cannot stall results.
// Reset (synchronous, active low) frees every slot and sets the active slot count to 16.
`timescale 1ns / 1ps

// Top level of the buffer change tracker; depends on bct_pkg, bct_ctrl and bct_datapath.
module buffer_change_tracker
    import bct_pkg::*;
#(
    parameter int SLOTS         = DEF_SLOTS,
    parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic [ADDR_PORT_W-1:0] i_block_address,
    input  logic [SIZE_W-1:0]      i_block_size,
    input  logic [CRC_W-1:0]       i_block_crc,
    output logic                   o_valid,
    output logic                   o_changed
);

    t_cmd w_cmd;

    // Sequencing of each request transfer.
    bct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // Slot table, compare and update.
    bct_datapath #(
        .SLOTS         (SLOTS),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_block_address (i_block_address),
        .i_block_size    (i_block_size),
        .i_block_crc     (i_block_crc),
        .o_changed       (o_changed)
    );

`ifndef SYNTHESIS
    // The compare cycle is always followed by a result.
    a_compare_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("compare cycle not followed by a result");

    // An accepted request leads to the compare cycle.
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter compare");

    // Every result comes from a compare cycle just before it.
    a_result_from_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding compare");

    // Compare never coincides with load or commit; load may coincide with commit.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.compare, w_cmd.commit}) && !(w_cmd.compare && w_cmd.load))
        else $error("overlapping datapath commands");
`endif

endmodule

// File: sim/bct_change_checker.sv
// Change checker for the buffer change tracker: mirrors the slot table, predicts each
// changed flag and compares it with the block's result. Depends on bct_pkg.
`timescale 1ns / 1ps

module bct_change_checker
    import bct_pkg::*;
#(
    parameter int SLOTS         = DEF_SLOTS,
    parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic [ADDR_PORT_W-1:0] i_block_address,
    input  logic [SIZE_W-1:0]      i_block_size,
    input  logic [CRC_W-1:0]       i_block_crc,
    input  logic                   i_valid,
    input  logic                   i_changed,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_unchanged
);

    // Only the low ADDRESS_WIDTH bits of the address take part in a match.
    localparam int ADDR_DROP = (ADDRESS_WIDTH >= ADDR_PORT_W) ? 0 : ADDR_PORT_W - ADDRESS_WIDTH;
    localparam logic [ADDR_PORT_W-1:0] ADDR_MASK = {ADDR_PORT_W{1'b1}} >> ADDR_DROP;

    // Mirror of the slot table and the active slot count.
    // The valid flags and the counters are two-state and start at zero.
    logic [ADDR_PORT_W-1:0] tracked_address [SLOTS];
    logic [SIZE_W-1:0]      tracked_size    [SLOTS];
    logic [CRC_W-1:0]       tracked_crc     [SLOTS];
    bit                     tracked_valid   [SLOTS];
    logic [CFG_W-1:0]       slot_limit = CFG_RESET;

    // Changed flags still owed by the block, oldest first.
    bit changed_due_q [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    // A count of zero acts as one slot; counts above the table size saturate.
    function automatic int slots_in_use();
        int n;
        n = int'(slot_limit);
        if (n < 1) n = 1;
        if (n > SLOTS) n = SLOTS;
        return n;
    endfunction

    task automatic store_slot(input int idx, input logic [ADDR_PORT_W-1:0] addr,
                              input logic [SIZE_W-1:0] size, input logic [CRC_W-1:0] crc);
        tracked_address[idx] = addr;
        tracked_size[idx]    = size;
        tracked_crc[idx]     = crc;
        tracked_valid[idx]   = 1'b1;
    endtask

    // Apply one request to the mirrored table and work out its changed flag.
    task automatic track_block(input logic [ADDR_PORT_W-1:0] addr,
                               input logic [SIZE_W-1:0] size,
                               input logic [CRC_W-1:0] crc, output bit changed);
        int n;
        bit settled;
        logic [ADDR_PORT_W-1:0] key;
        key     = addr & ADDR_MASK;
        n       = slots_in_use();
        changed = 1'b1;
        // An address of zero is reported changed and never stored.
        settled = (key == '0);
        for (int i = 0; i < n && !settled; i++) begin
            if (!tracked_valid[i]) begin
                store_slot(i, key, size, crc);
                settled = 1'b1;
            end else if (tracked_address[i] == key && tracked_size[i] == size) begin
                if (tracked_crc[i] == crc) changed = 1'b0;
                else tracked_crc[i] = crc;
                settled = 1'b1;
            end
        end
        // Every active slot is taken by another block: drop the oldest, append at the end.
        if (!settled) begin
            for (int i = 0; i + 1 < n; i++) begin
                tracked_address[i] = tracked_address[i+1];
                tracked_size[i]    = tracked_size[i+1];
                tracked_crc[i]     = tracked_crc[i+1];
                tracked_valid[i]   = tracked_valid[i+1];
            end
            store_slot(n - 1, key, size, crc);
        end
    endtask

    // Results are checked before a request of the same edge is predicted, since a
    // transfer of a new request can coincide with the result of the previous one.
    always @(posedge i_clk) begin : watch
        bit want;
        if (!i_rst_n) begin
            foreach (tracked_valid[k]) tracked_valid[k] = 1'b0;
            slot_limit = CFG_RESET;
            changed_due_q.delete();
        end else begin
            if (i_valid) begin
                if (changed_due_q.size() == 0) begin
                    report_mismatch($sformatf("result changed=%b with no request outstanding",
                                              i_changed));
                end else begin
                    want = changed_due_q.pop_front();
                    if (i_changed !== want)
                        report_mismatch($sformatf("changed is %b, predicted %b", i_changed, want));
                    o_results++;
                    if (i_changed === 1'b0) o_unchanged++;
                end
            end
            if (i_cfg_we) slot_limit = i_cfg_data;
            if (i_start && !i_busy) begin
                track_block(i_block_address, i_block_size, i_block_crc, want);
                changed_due_q.push_back(want);
            end
        end
        o_pending = changed_due_q.size();
    end

endmodule

// File: sim/buffer_change_tracker_tb.sv
// Testbench top for the buffer change tracker: drives requests and slot-count writes,
// watches for stalls and gives the verdict. Depends on bct_pkg and bct_change_checker.
`timescale 1ns / 1ps

module buffer_change_tracker_tb;
    import bct_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_GAP       = 40;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 55;
    localparam int KEY_ADDRS     = 8;
    localparam int KEY_SIZES     = 3;

    // Slot count for each random phase, and the sender idle percentage cycle.
    localparam int PHASE_SLOTS [RANDOM_PHASES] = '{16, 1, 0, 31, 2, 5, 8, 17, 3, 16};
    localparam int PHASE_IDLE  [4]             = '{0, 59, 0, 16};

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   start         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic [ADDR_PORT_W-1:0] block_address = '0;
    logic [SIZE_W-1:0]      block_size    = '0;
    logic [CRC_W-1:0]       block_crc     = '0;
    logic                   busy;
    logic                   valid;
    logic                   changed;

    int fail_count;
    int pending;
    int results;
    int unchanged;
    int requests_sent = 0;
    int settings_used = 0;
    int idle_cycles   = 0;

    // A small pool of blocks, so that repeats, updates and evictions happen often.
    logic [ADDR_PORT_W-1:0] key_address [KEY_ADDRS];
    logic [SIZE_W-1:0]      key_size    [KEY_SIZES];

    always #(CLK_PERIOD / 2) clk = ~clk;

    buffer_change_tracker dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_block_address (block_address),
        .i_block_size    (block_size),
        .i_block_crc     (block_crc),
        .o_valid         (valid),
        .o_changed       (changed)
    );

    bct_change_checker change_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_block_address (block_address),
        .i_block_size    (block_size),
        .i_block_crc     (block_crc),
        .i_valid         (valid),
        .i_changed       (changed),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (results),
        .o_unchanged     (unchanged)
    );

    // Stall watchdog: any request or result transfer restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("No transfer for %0d cycles, stopping.", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request and hold it until it is taken, then maybe idle for a while.
    task automatic send_block(input logic [ADDR_PORT_W-1:0] addr, input logic [SIZE_W-1:0] size,
                              input logic [CRC_W-1:0] crc, input int idle_pct);
        int gap;
        start         <= 1'b1;
        block_address <= addr;
        block_size    <= size;
        block_crc     <= crc;
        do @(posedge clk); while (busy);
        requests_sent++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly blocks from the pool with a few CRC values; the rest zero or fully random.
    task automatic send_random_block(input int idle_pct);
        logic [ADDR_PORT_W-1:0] addr;
        logic [SIZE_W-1:0]      size;
        logic [CRC_W-1:0]       crc;
        int                     pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            addr = '0;
            size = SIZE_W'($urandom);
            crc  = CRC_W'($urandom);
        end else if (pick < 25) begin
            addr = ADDR_PORT_W'($urandom);
            size = SIZE_W'($urandom);
            crc  = CRC_W'($urandom);
        end else begin
            addr = key_address[$urandom_range(KEY_ADDRS - 1)];
            size = key_size[$urandom_range(KEY_SIZES - 1)];
            crc  = ($urandom_range(9) == 0) ? CRC_W'($urandom) : CRC_W'($urandom_range(2));
        end
        send_block(addr, size, crc, idle_pct);
    endtask

    // Stop offering requests and wait until every owed result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_slot_limit(input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int idle_pct;
        foreach (key_address[k]) begin
            key_address[k] = ADDR_PORT_W'($urandom);
            if (key_address[k] == '0) key_address[k] = ADDR_PORT_W'(1);
        end
        foreach (key_size[k]) key_size[k] = SIZE_W'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full table: zero address, field extremes, repeat, CRC update, size as part of the key.
        send_block('0, '1, '1, 0);
        send_block('1, '1, '1, 0);
        send_block('1, '1, '1, 0);
        send_block('1, '1, '0, 0);
        send_block('1, '1, '0, 0);
        send_block('1, '0, '0, 0);
        send_block(1, '0, '0, 0);
        send_block('0, '0, '0, 0);
        send_block(1, '0, '0, 0);

        // One slot: the new block pushes out the first, later slots are not searched.
        drain_results();
        write_slot_limit(5'd1);
        send_block(2, 1, 1, 0);
        send_block(2, 1, 1, 0);
        send_block('1, '1, '0, 0);

        // A count of zero behaves as one slot.
        drain_results();
        write_slot_limit(5'd0);
        send_block('1, '1, '0, 0);
        send_block(3, 2, 2, 0);

        // Three slots: a kept slot comes back into view, then an eviction and a re-query.
        drain_results();
        write_slot_limit(5'd3);
        send_block(1, '0, '0, 0);
        send_block(4, 4, 4, 0);
        send_block(3, 2, 2, 0);

        // An oversized count saturates to the full table.
        drain_results();
        write_slot_limit(5'd31);
        send_block(5, 5, 5, 0);
        send_block(5, 5, 5, 0);
        send_block(4, 4, '1, 0);

        // Random phases, each with its own slot count and sender idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            write_slot_limit(CFG_W'(PHASE_SLOTS[p]));
            idle_pct = PHASE_IDLE[p % 4];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == PHASE_ITEMS / 2) drain_results();
                send_random_block(idle_pct);
            end
        end

        drain_results();
        repeat (4) @(posedge clk);

        $display("Covered %0d requests under %0d slot-count settings.",
                 requests_sent, settings_used);
        $display("Checked %0d results, %0d of them unchanged.", results, unchanged);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
